>>> src/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg
// Shared types and constants for the strict UTF-8 decoder: byte ranges for
// lead and continuation bytes, and the bundle that carries the results of
// one input byte from the decode stage to the result queue.
// ----------------------------------------------------------------------------
package usd_pkg;

   localparam int CpWidth = 21;

   // Code point emitted for a rejected byte after reset (U+FFFD).
   localparam logic [CpWidth-1:0] ReplacementReset = 21'h00FFFD;

   // Lead bytes that open a sequence with special first-continuation limits.
   localparam logic [7:0] LeadE0 = 8'hE0;
   localparam logic [7:0] LeadED = 8'hED;
   localparam logic [7:0] LeadF0 = 8'hF0;
   localparam logic [7:0] LeadF4 = 8'hF4;

   // Limits of the first continuation byte.
   localparam logic [7:0] ContLo    = 8'h80;
   localparam logic [7:0] ContHi    = 8'hBF;
   localparam logic [7:0] ContLoE0  = 8'hA0;
   localparam logic [7:0] ContHiED  = 8'h9F;
   localparam logic [7:0] ContLoF0  = 8'h90;
   localparam logic [7:0] ContHiF4  = 8'h8F;

   // Continuation byte form 10xxxxxx.
   localparam logic [1:0] ContTag = 2'b10;

   // Results of one byte: rep_count replacements, then an optional value.
   typedef struct packed {
      logic [2:0]         rep_count;
      logic               has_value;
      logic [CpWidth-1:0] value;
   } bundle_type;

endpackage

>>> src/utf8_strict_decoder.sv
// A code point passes the input stage register and the bundle queue before
// it is offered. Throughput: one byte per cycle while the queue has room
// and each byte yields at most one result; a byte that yields more holds the
// single result port for each result in turn while the two-entry queue drains.
// Reset clears the sequence state, the input stage and the queue, and sets
// the replacement code to U+FFFD.
// ----------------------------------------------------------------------------
// utf8_strict_decoder
// Strict streaming UTF-8 decoder: one byte per input beat, one code point
// or replacement per result beat, with overlong, surrogate and out-of-range
// forms rejected.
// ----------------------------------------------------------------------------
module utf8_strict_decoder
   import usd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [CpWidth-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_byte_in,
   input  logic               req_stream_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CpWidth-1:0] rsp_code_point,
   output logic               rsp_is_replacement,
   output logic               rsp_run_last
);

   logic [CpWidth-1:0] repl_ff;
   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               in_end_ff;
   bundle_type         queue_ff [2];
   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic [1:0]         count_ff;
   logic [1:0]         item_ff;
   logic               decode_fire;
   logic               push;
   logic               pop;
   logic               rsp_beat;
   logic               item_rep;
   logic               item_last;
   logic [2:0]         total;
   bundle_type         decoded;
   bundle_type         head;

   // Replacement code register.
   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= ReplacementReset;
      end else if (csr_wr_en) begin
         repl_ff <= csr_wr_data;
      end
   end

   // The input stage moves on whenever the queue has room.
   assign decode_fire = in_valid_ff && (count_ff != 2'd2);
   assign req_ready   = !in_valid_ff || decode_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_in;
         in_end_ff  <= req_stream_end;
      end
   end

   usd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (decode_fire),
      .byte_in    (in_byte_ff),
      .stream_end (in_end_ff),
      .bundle     (decoded)
   );

   // Bundles that carry no result never enter the queue.
   assign push = decode_fire && ((decoded.rep_count != 3'd0) || decoded.has_value);

   // Result side: replacements first, then the value if there is one.
   assign head      = queue_ff[rd_ptr_ff];
   assign total     = head.rep_count + {2'b00, head.has_value};
   assign item_rep  = ({1'b0, item_ff} < head.rep_count);
   assign item_last = ({1'b0, item_ff} == (total - 3'd1));
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_beat  = rsp_valid && rsp_ready;
   assign pop       = rsp_beat && item_last;

   assign rsp_code_point     = item_rep ? repl_ff : head.value;
   assign rsp_is_replacement = item_rep;
   assign rsp_run_last       = item_last;

   // Bundle queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

   // Queue pointers, fill count and position within the head bundle.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         item_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
            item_ff   <= 2'd0;
         end else if (rsp_beat) begin
            item_ff <= item_ff + 2'd1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

>>> src/usd_decode.sv
// ----------------------------------------------------------------------------
// usd_decode
// Sequence state of the decoder and the single-pass logic that turns one
// byte into a bundle of results: flushed replacements, then at most one
// decoded value or byte replacement, then any end-of-stream flush.
// ----------------------------------------------------------------------------
module usd_decode
   import usd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] byte_in,
   input  logic       stream_end,
   output bundle_type bundle
);

   logic [7:0]         lead_ff, lead_in;
   logic [1:0]         need_ff, need_in;
   logic [1:0]         seen_ff, seen_in;
   logic [CpWidth-1:0] part_ff, part_in;

   // Decode of one byte against the open sequence.
   always_comb begin
      logic       ok;
      logic       consumed;
      logic       reject;
      logic       start_rep;
      logic       end_flush;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [1:0] seen_inc;
      logic [2:0] reject_count;
      logic [2:0] end_count;

      lead_in      = lead_ff;
      need_in      = need_ff;
      seen_in      = seen_ff;
      part_in      = part_ff;
      consumed     = 1'b0;
      reject       = 1'b0;
      start_rep    = 1'b0;
      bundle       = '0;
      reject_count = {1'b0, seen_ff} + 3'd1;

      // Range of the continuation byte that may follow.
      lo = ContLo;
      hi = ContHi;
      if (lead_ff == LeadE0) lo = ContLoE0;
      if (lead_ff == LeadED) hi = ContHiED;
      if (lead_ff == LeadF0) lo = ContLoF0;
      if (lead_ff == LeadF4) hi = ContHiF4;
      if (seen_ff == 2'd0) begin
         ok = (byte_in >= lo) && (byte_in <= hi);
      end else begin
         ok = (byte_in[7:6] == ContTag);
      end
      seen_inc = seen_ff + 2'd1;

      // Continue or abandon an open sequence.
      if (need_ff != 2'd0) begin
         if (ok) begin
            consumed = 1'b1;
            part_in  = {part_ff[CpWidth-7:0], byte_in[5:0]};
            seen_in  = seen_inc;
            if (seen_inc >= need_ff) begin
               bundle.has_value = 1'b1;
               bundle.value     = part_in;
               lead_in = '0;
               need_in = '0;
               seen_in = '0;
               part_in = '0;
            end
         end else begin
            reject  = 1'b1;
            lead_in = '0;
            need_in = '0;
            seen_in = '0;
            part_in = '0;
         end
      end

      // Handle the byte as the start of a new item.
      if (!consumed) begin
         case (byte_in) inside
            [8'h00:8'h7F]: begin
               bundle.has_value = 1'b1;
               bundle.value     = {{(CpWidth-8){1'b0}}, byte_in};
            end
            [8'hC2:8'hDF]: begin
               lead_in = byte_in;
               need_in = 2'd1;
               seen_in = 2'd0;
               part_in = {{(CpWidth-5){1'b0}}, byte_in[4:0]};
            end
            [8'hE0:8'hEF]: begin
               lead_in = byte_in;
               need_in = 2'd2;
               seen_in = 2'd0;
               part_in = {{(CpWidth-4){1'b0}}, byte_in[3:0]};
            end
            [8'hF0:8'hF4]: begin
               lead_in = byte_in;
               need_in = 2'd3;
               seen_in = 2'd0;
               part_in = {{(CpWidth-3){1'b0}}, byte_in[2:0]};
            end
            default: begin
               start_rep = 1'b1;
            end
         endcase
      end

      // A sequence still open at the end of the stream is flushed.
      end_flush = stream_end && (need_in != 2'd0);
      end_count = {1'b0, seen_in} + 3'd1;
      if (end_flush) begin
         lead_in = '0;
         need_in = '0;
         seen_in = '0;
         part_in = '0;
      end

      bundle.rep_count = (reject ? reject_count : 3'd0)
                       + {2'b00, start_rep}
                       + (end_flush ? end_count : 3'd0);
   end

   // Sequence state, advanced once per decoded byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= '0;
         need_ff <= '0;
         seen_ff <= '0;
         part_ff <= '0;
      end else if (step) begin
         lead_ff <= lead_in;
         need_ff <= need_in;
         seen_ff <= seen_in;
         part_ff <= part_in;
      end
   end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the strict UTF-8 decoder. Bytes are sent one per
// beat, and a scoreboard predicts every code point and replacement that the
// block should return. Each result beat is checked in order, field by field.
// The run covers a directed set of edge cases, then mostly well-formed
// random sequences with some broken ones and some noise mixed in. The
// replacement code is changed between phases, and both sides of the block
// stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import usd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Byte ranges that select the length of a sequence.
   localparam logic [7:0] AsciiTop = 8'h7F;
   localparam logic [7:0] Lead2Lo  = 8'hC2;
   localparam logic [7:0] Lead2Hi  = 8'hDF;
   localparam logic [7:0] Lead3Lo  = 8'hE0;
   localparam logic [7:0] Lead3Hi  = 8'hEF;
   localparam logic [7:0] Lead4Lo  = 8'hF0;
   localparam logic [7:0] Lead4Hi  = 8'hF4;

   // Bit 8 of a directed entry marks the end of the stream.
   localparam logic [8:0] EndFlag = 9'h100;

   localparam int HoldCycles  = 300;
   localparam int SettleWait  = 8;
   localparam int CycleLimit  = 200000;
   localparam int PrintLimit  = 50;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               is_replacement;
      logic               run_last;
   } code_point_type;

   // Predicts the decoder's output and holds the results still to come.
   class code_point_scoreboard_type;
      logic [CpWidth-1:0] repl_code;
      logic [7:0]         lead;
      logic [1:0]         need;
      logic [1:0]         seen;
      logic [CpWidth-1:0] partial;
      code_point_type     step_q[$];
      code_point_type     pending_points[$];
      int                 mismatches;
      int                 checked;
      int                 bytes_noted;

      function new();
         repl_code   = ReplacementReset;
         mismatches  = 0;
         checked     = 0;
         bytes_noted = 0;
         close_sequence();
      endfunction

      function void close_sequence();
         lead    = '0;
         need    = '0;
         seen    = '0;
         partial = '0;
      endfunction

      function void set_replacement(logic [CpWidth-1:0] value);
         repl_code = value;
      endfunction

      function void emit(logic [CpWidth-1:0] cp, logic rep);
         code_point_type r;
         r.code_point     = cp;
         r.is_replacement = rep;
         r.run_last       = 1'b0;
         step_q = {step_q, r};
      endfunction

      // One replacement for the lead and one for each continuation taken.
      function void flush_open();
         repeat (int'(seen) + 1) emit(repl_code, 1'b1);
         close_sequence();
      endfunction

      function void open_sequence(logic [7:0] b, logic [1:0] count,
                                  logic [CpWidth-1:0] bits);
         lead    = b;
         need    = count;
         seen    = '0;
         partial = bits;
      endfunction

      // A byte seen with no sequence open.
      function void start_byte(logic [7:0] b);
         if (b <= AsciiTop) begin
            emit({{(CpWidth-8){1'b0}}, b}, 1'b0);
         end else if (b >= Lead2Lo && b <= Lead2Hi) begin
            open_sequence(b, 2'd1, {16'b0, b[4:0]});
         end else if (b >= Lead3Lo && b <= Lead3Hi) begin
            open_sequence(b, 2'd2, {17'b0, b[3:0]});
         end else if (b >= Lead4Lo && b <= Lead4Hi) begin
            open_sequence(b, 2'd3, {18'b0, b[2:0]});
         end else begin
            emit(repl_code, 1'b1);
         end
      endfunction

      // Works out the results of one accepted input beat.
      function void note_byte(logic [7:0] b, logic fin);
         logic [7:0] lo;
         logic [7:0] hi;
         bit         ok;
         bit         consumed;
         step_q.delete();
         consumed = 1'b0;
         bytes_noted++;
         if (need != 0) begin
            // The first continuation has limits that depend on the lead.
            if (seen == 0) begin
               lo = ContLo;
               hi = ContHi;
               if (lead == LeadE0) lo = ContLoE0;
               if (lead == LeadED) hi = ContHiED;
               if (lead == LeadF0) lo = ContLoF0;
               if (lead == LeadF4) hi = ContHiF4;
               ok = (b >= lo) && (b <= hi);
            end else begin
               ok = (b[7:6] == ContTag);
            end
            if (ok) begin
               partial  = {partial[CpWidth-7:0], b[5:0]};
               seen     = seen + 2'd1;
               consumed = 1'b1;
               if (seen >= need) begin
                  emit(partial, 1'b0);
                  close_sequence();
               end
            end else begin
               flush_open();
            end
         end
         // A rejected byte is taken again as a fresh start.
         if (!consumed) start_byte(b);
         if (fin && need != 0) flush_open();
         if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
         foreach (step_q[i]) pending_points = {pending_points, step_q[i]};
      endfunction

      task report_mismatch(string what, logic [CpWidth-1:0] got,
                           logic [CpWidth-1:0] want);
         if (mismatches < PrintLimit)
            $display("MISMATCH at result %0d: %s got %h, expected %h",
                     checked, what, got, want);
         mismatches++;
      endtask

      // Compares one result beat with the oldest prediction.
      task check_result(logic [CpWidth-1:0] cp, logic rep, logic last);
         code_point_type want;
         if (pending_points.size() == 0) begin
            report_mismatch("unexpected result, code point", cp, '0);
         end else begin
            want = pending_points.pop_front();
            checked++;
            if (cp !== want.code_point)
               report_mismatch("code_point", cp, want.code_point);
            if (rep !== want.is_replacement)
               report_mismatch("is_replacement", rep, want.is_replacement);
            if (last !== want.run_last)
               report_mismatch("run_last", last, want.run_last);
         end
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [CpWidth-1:0] csr_wr_data;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_byte_in;
   logic               req_stream_end;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [CpWidth-1:0] rsp_code_point;
   logic               rsp_is_replacement;
   logic               rsp_run_last;

   code_point_scoreboard_type sb;
   bit                 gaps_enabled;
   bit                 stalls_enabled;
   bit                 hold_request;
   int                 cycles;
   logic [7:0]         seq_bytes[$];

   utf8_strict_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_in        (req_byte_in),
      .req_stream_end     (req_stream_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code_point     (rsp_code_point),
      .rsp_is_replacement (rsp_is_replacement),
      .rsp_run_last       (rsp_run_last)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog on the whole run.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycles, sb.pending_points.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Every result beat is checked as it is accepted.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         sb.check_result(rsp_code_point, rsp_is_replacement, rsp_run_last);
   end

   // Result side: random stall bursts, and one long hold-off when asked.
   initial begin : ready_driver
      int burst;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready    = 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end
         if (stalls_enabled && $urandom_range(0, 4) == 0) begin
            burst     = $urandom_range(1, 8);
            rsp_ready = 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // Offers one byte and waits until its beat is accepted.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      @(negedge clock);
      if (gaps_enabled && $urandom_range(0, 5) == 0) begin
         gap       = $urandom_range(1, 8);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_byte_in    = b;
      req_stream_end = fin;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      sb.note_byte(b, fin);
   endtask

   task automatic idle_input();
      @(negedge clock);
      req_valid      = 1'b0;
      req_stream_end = 1'b0;
   endtask

   // Waits until every predicted result has come back, then lets the
   // pipeline settle, since a lead byte leaves no result behind it.
   task automatic drain();
      while (sb.pending_points.size() != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   task automatic write_replacement(input logic [CpWidth-1:0] value);
      idle_input();
      drain();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      sb.set_replacement(value);
   endtask

   // Appends the UTF-8 form of a scalar value to seq_bytes.
   function automatic void encode_scalar(logic [CpWidth-1:0] cp);
      if (cp < 21'h80) begin
         seq_bytes = {seq_bytes, cp[7:0]};
      end else if (cp < 21'h800) begin
         seq_bytes = {seq_bytes, {3'b110, cp[10:6]}};
         seq_bytes = {seq_bytes, {2'b10, cp[5:0]}};
      end else if (cp < 21'h10000) begin
         seq_bytes = {seq_bytes, {4'b1110, cp[15:12]}};
         seq_bytes = {seq_bytes, {2'b10, cp[11:6]}};
         seq_bytes = {seq_bytes, {2'b10, cp[5:0]}};
      end else begin
         seq_bytes = {seq_bytes, {5'b11110, cp[20:18]}};
         seq_bytes = {seq_bytes, {2'b10, cp[17:12]}};
         seq_bytes = {seq_bytes, {2'b10, cp[11:6]}};
         seq_bytes = {seq_bytes, {2'b10, cp[5:0]}};
      end
   endfunction

   function automatic logic [CpWidth-1:0] random_scalar();
      logic [CpWidth-1:0] cp;
      case ($urandom_range(0, 3))
         0: cp = CpWidth'($urandom_range(0, 21'h7F));
         1: cp = CpWidth'($urandom_range(21'h80, 21'h7FF));
         2: begin
            cp = CpWidth'($urandom_range(21'h800, 21'hFFFF));
            // Move surrogates down into the valid range below them.
            if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h800;
         end
         default: cp = CpWidth'($urandom_range(21'h10000, 21'h10FFFF));
      endcase
      return cp;
   endfunction

   // Edge cases: field extremes, the first-continuation limits of each
   // special lead, bare and never-valid bytes, a flush on a later
   // continuation, and the stream ending part way through a sequence.
   task automatic send_directed();
      logic [8:0] entries[$];
      entries = '{9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0DF, 9'h0BF,
                  9'h0E0, 9'h09F, 9'h0ED, 9'h0A0, 9'h0F0, 9'h08F,
                  9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h0C1, 9'h0FF,
                  9'h080, 9'h0F1, 9'h080, 9'h080, 9'h0C3, 9'h0A9,
                  9'h0E2, EndFlag | 9'h082, EndFlag | 9'h0C3};
      foreach (entries[i]) send_byte(entries[i][7:0], entries[i][8]);
   endtask

   // Mostly valid sequences with random content; the rest are cut short,
   // carry a corrupted continuation, or are single noise bytes.
   task automatic send_stream(input int byte_count);
      int   sent;
      int   kind;
      int   spot;
      logic fin;
      sent = 0;
      while (sent < byte_count) begin
         seq_bytes.delete();
         kind = $urandom_range(0, 99);
         if (kind < 94) encode_scalar(random_scalar());
         if (kind >= 80 && kind < 88 && seq_bytes.size() > 1) begin
            spot = $urandom_range(1, seq_bytes.size() - 1);
            while (seq_bytes.size() > spot) void'(seq_bytes.pop_back());
         end else if (kind >= 88 && kind < 94 && seq_bytes.size() > 1) begin
            spot = $urandom_range(1, seq_bytes.size() - 1);
            seq_bytes[spot] = 8'($urandom_range(0, 255));
         end else if (kind >= 94) begin
            seq_bytes = {seq_bytes, 8'($urandom_range(0, 255))};
         end
         foreach (seq_bytes[i]) begin
            fin = ($urandom_range(0, 39) == 0) ||
                  (i == seq_bytes.size() - 1 && $urandom_range(0, 7) == 0);
            send_byte(seq_bytes[i], fin);
            sent++;
         end
      end
   endtask

   // Main sequence of phases.
   initial begin
      sb             = new();
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_valid      = 1'b0;
      req_byte_in    = '0;
      req_stream_end = 1'b0;
      gaps_enabled   = 1'b1;
      stalls_enabled = 1'b1;
      hold_request   = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Replacement code as left by reset.
      send_directed();

      write_replacement('0);
      send_stream(90);

      // Long result-side hold-off while bytes keep coming.
      write_replacement(21'h10FFFF);
      hold_request = 1'b1;
      send_stream(90);

      write_replacement(21'h0FFFFF);
      send_stream(80);

      // Closing stretch at full rate with no idling.
      write_replacement(CpWidth'($urandom_range(0, 21'h10FFFF)));
      gaps_enabled   = 1'b0;
      stalls_enabled = 1'b0;
      send_stream(90);

      idle_input();
      drain();
      while (sb.pending_points.size() != 0) begin
         sb.report_mismatch("missing result, code point", '0,
                            sb.pending_points[0].code_point);
         void'(sb.pending_points.pop_front());
      end

      $display("Summary: %0d bytes in, %0d results checked over five replacement codes,",
               sb.bytes_noted, sb.checked);
      $display("Summary: with edge cases, broken sequences, stream ends and a %0d-cycle stall.",
               HoldCycles);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches found.", sb.mismatches);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/usd_pkg.sv
src/usd_decode.sv
src/utf8_strict_decoder.sv
dv/testbench.sv
